// ===== hdl/adaptive_average_pool_2d_assert.svh =====
// Assertion macros for the adaptive average pooling block.
`ifndef ADAPTIVE_AVERAGE_POOL_2D_ASSERT_SVH
`define ADAPTIVE_AVERAGE_POOL_2D_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising edge outside reset.
`define AAP_ASSERT_IMPLY(label, clock, reset, cond, prop) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
    else $error("adaptive_average_pool_2d: implication check failed");

// Next-cycle implication.
`define AAP_ASSERT_NEXT(label, clock, reset, cond, prop) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
    else $error("adaptive_average_pool_2d: next-cycle check failed");

`else

`define AAP_ASSERT_IMPLY(label, clock, reset, cond, prop)
`define AAP_ASSERT_NEXT(label, clock, reset, cond, prop)

`endif

`endif

// ===== hdl/aap_pkg.sv =====
// Shared types and constants for the adaptive average pooling block.
`timescale 1ns / 1ps
`default_nettype none

package aap_pkg;

  localparam int DIM_W      = 7;   // configured plane and grid sizes
  localparam int COORD_W    = 6;   // row and col of an item
  localparam int SAMPLE_W   = 16;  // stored sample and result
  localparam int CFG_IDX_W  = 2;
  localparam int OUT_LIMIT  = 64;  // largest output grid side
  localparam int BND_W      = 14;  // window bound numerator
  localparam int REM_W      = 14;  // divisor and remainder
  localparam int NUM_W      = 29;  // magnitude of the window sum
  localparam int SUM_W      = 30;  // signed window sum
  localparam int CNT_W      = 5;   // divider step counter

  localparam logic FUNC_STORE   = 1'b0;
  localparam logic FUNC_COMPUTE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 2'd3;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_BMUL  = 9'b000000010,
    S_BDIV  = 9'b000000100,
    S_BASE  = 9'b000001000,
    S_CNT   = 9'b000010000,
    S_WALK  = 9'b000100000,
    S_LAST  = 9'b001000000,
    S_MLOAD = 9'b010000000,
    S_MDIV  = 9'b100000000
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/adaptive_average_pool_2d.sv =====
// Adaptive 2D average pooling over one plane of signed 16-bit samples.
`timescale 1ns / 1ps
`default_nettype none

// A store transaction (func = store) writes value at (row, col) of the plane
// in the start cycle; it gives no result, and stores outside the configured
// in_height x in_width plane are dropped. A compute transaction names a cell
// of the out_height x out_width grid; the block takes it, raises busy, and
// later shows exactly one result on average/range_error with result_valid
// high for one cycle. The receiver cannot stall: sample the result whenever
// result_valid is high. A compute outside the grid answers range_error = 1,
// average = 0 in the cycle after start. An in-range compute holds busy until
// its result. One shared restoring divider, one quotient bit per cycle, first
// finds the four window bounds at 14 steps each, then does the 29-step divide
// of the window sum by the sample count (window rows x window columns).
// Between them the window is read from the plane RAM one sample per cycle
// through its single read port. Zero register values act as 1, values above
// the plane limits (MAX_HEIGHT, MAX_WIDTH, 64 for the grid) act as the limit.
// Configuration writes are always taken (cfg_ready is tied high) and must
// only happen while no compute is in flight. The plane RAM needs no clearing
// pass; a window must only cover samples that were written.
module adaptive_average_pool_2d #(
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_WIDTH  = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // command channel
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           func,
  input  wire logic [aap_pkg::COORD_W-1:0]    row,
  input  wire logic [aap_pkg::COORD_W-1:0]    col,
  input  wire logic signed [aap_pkg::SAMPLE_W-1:0] value,
  // result strobe
  output logic                                result_valid,
  output logic signed [aap_pkg::SAMPLE_W-1:0] average,
  output logic                                range_error,
  // configuration write channel
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [aap_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [aap_pkg::DIM_W-1:0]      cfg_data
);

  localparam int DEPTH  = MAX_HEIGHT * MAX_WIDTH;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IH_RST = (MAX_HEIGHT < 64) ? MAX_HEIGHT : 64;
  localparam int IW_RST = (MAX_WIDTH < 64) ? MAX_WIDTH : 64;

  localparam int DIM_W    = aap_pkg::DIM_W;
  localparam int COORD_W  = aap_pkg::COORD_W;
  localparam int SAMPLE_W = aap_pkg::SAMPLE_W;
  localparam int BND_W    = aap_pkg::BND_W;
  localparam int REM_W    = aap_pkg::REM_W;
  localparam int NUM_W    = aap_pkg::NUM_W;
  localparam int SUM_W    = aap_pkg::SUM_W;
  localparam int CNT_W    = aap_pkg::CNT_W;

  // ---------------------------------------------------------------- config
  logic [DIM_W-1:0] in_height, in_width, out_height, out_width;
  logic [DIM_W-1:0] cfg_in_h, cfg_in_w, cfg_out_h, cfg_out_w;

  assign cfg_ready = 1'b1;

  // clamp: zero acts as one, oversize acts as the limit
  always_comb begin
    cfg_in_h  = cfg_data;
    cfg_in_w  = cfg_data;
    cfg_out_h = cfg_data;
    if (cfg_data == '0) begin
      cfg_in_h  = DIM_W'(1);
      cfg_in_w  = DIM_W'(1);
      cfg_out_h = DIM_W'(1);
    end else begin
      if (32'(cfg_data) > MAX_HEIGHT) cfg_in_h = DIM_W'(MAX_HEIGHT);
      if (32'(cfg_data) > MAX_WIDTH)  cfg_in_w = DIM_W'(MAX_WIDTH);
      if (32'(cfg_data) > aap_pkg::OUT_LIMIT) cfg_out_h = DIM_W'(aap_pkg::OUT_LIMIT);
    end
    cfg_out_w = cfg_out_h;
  end

  // ---------------------------------------------------------------- command decode
  aap_pkg::state_t state;
  logic accept, store_ok, grid_ok;

  assign busy     = (state != aap_pkg::S_IDLE);
  assign accept   = start && !busy;
  assign store_ok = ({1'b0, row} < in_height) && ({1'b0, col} < in_width);
  assign grid_ok  = ({1'b0, row} < out_height) && ({1'b0, col} < out_width);

  // ---------------------------------------------------------------- plane store
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;

  assign ram_we    = accept && (func == aap_pkg::FUNC_STORE) && store_ok;
  assign ram_waddr = ADDR_W'(32'(row) * MAX_WIDTH) + ADDR_W'(col);

  aap_ram #(
    .DATA_W (SAMPLE_W),
    .DEPTH  (DEPTH)
  ) u_plane (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (value),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // ---------------------------------------------------------------- sequencer state
  logic [1:0]        bnd_idx;
  logic [DIM_W-1:0]  bnd [4];          // r0, r1, c0, c1
  logic [COORD_W-1:0] row_q, col_q;
  logic [DIM_W-1:0]  wr, wc;
  logic [ADDR_W-1:0] row_base;
  logic              rd_pend;
  logic signed [SUM_W-1:0] sum;
  logic              neg;

  // shared divider
  logic [NUM_W-1:0] div_num, div_quo, div_quo_next;
  logic [REM_W-1:0] div_rem, div_den, div_rem_next;
  logic [CNT_W-1:0] div_cnt;
  logic [REM_W:0]   rem_sh;
  logic             div_ge;

  assign rem_sh       = {div_rem, div_num[NUM_W-1]};
  assign div_ge       = (rem_sh >= {1'b0, div_den});
  assign div_rem_next = div_ge ? REM_W'(rem_sh - {1'b0, div_den}) : REM_W'(rem_sh);
  assign div_quo_next = {div_quo[NUM_W-2:0], div_ge};

  // window bound numerator: a*in_n, plus out_n-1 for the ceiling
  logic [DIM_W-1:0] b_a, b_in, b_out;
  logic [BND_W-1:0] b_num;

  assign b_a   = (bnd_idx[1] ? {1'b0, col_q} : {1'b0, row_q}) + DIM_W'(bnd_idx[0]);
  assign b_in  = bnd_idx[1] ? in_width  : in_height;
  assign b_out = bnd_idx[1] ? out_width : out_height;
  assign b_num = BND_W'(b_a) * BND_W'(b_in)
               + (bnd_idx[0] ? BND_W'(b_out) - BND_W'(1) : '0);

  assign ram_raddr = row_base + ADDR_W'(wc);

  logic signed [SUM_W-1:0] sum_add;
  logic        [SUM_W-1:0] sum_abs;
  logic [SAMPLE_W-1:0]     quo16;

  assign sum_add = sum + {{(SUM_W-SAMPLE_W){ram_rdata[SAMPLE_W-1]}}, ram_rdata};
  assign sum_abs = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign quo16   = div_quo_next[SAMPLE_W-1:0];

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= aap_pkg::S_IDLE;
      result_valid <= 1'b0;
      rd_pend      <= 1'b0;
      in_height    <= DIM_W'(IH_RST);
      in_width     <= DIM_W'(IW_RST);
      out_height   <= DIM_W'(8);
      out_width    <= DIM_W'(8);
    end else begin
      result_valid <= 1'b0;
      rd_pend      <= (state == aap_pkg::S_WALK);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          aap_pkg::REG_IN_HEIGHT:  in_height  <= cfg_in_h;
          aap_pkg::REG_IN_WIDTH:   in_width   <= cfg_in_w;
          aap_pkg::REG_OUT_HEIGHT: out_height <= cfg_out_h;
          aap_pkg::REG_OUT_WIDTH:  out_width  <= cfg_out_w;
          default: ;
        endcase
      end
      case (state)
        aap_pkg::S_IDLE: begin
          if (accept && (func == aap_pkg::FUNC_COMPUTE)) begin
            if (grid_ok) state <= aap_pkg::S_BMUL;
            else result_valid <= 1'b1;
          end
        end
        aap_pkg::S_BMUL: state <= aap_pkg::S_BDIV;
        aap_pkg::S_BDIV: begin
          if (div_cnt == CNT_W'(1)) begin
            state <= (bnd_idx == 2'd3) ? aap_pkg::S_BASE : aap_pkg::S_BMUL;
          end
        end
        aap_pkg::S_BASE: state <= aap_pkg::S_CNT;
        aap_pkg::S_CNT:  state <= aap_pkg::S_WALK;
        aap_pkg::S_WALK: begin
          if ((wc == bnd[3] - DIM_W'(1)) && (wr == bnd[1] - DIM_W'(1))) begin
            state <= aap_pkg::S_LAST;
          end
        end
        aap_pkg::S_LAST:  state <= aap_pkg::S_MLOAD;
        aap_pkg::S_MLOAD: state <= aap_pkg::S_MDIV;
        aap_pkg::S_MDIV: begin
          if (div_cnt == CNT_W'(1)) begin
            state        <= aap_pkg::S_IDLE;
            result_valid <= 1'b1;
          end
        end
        default: state <= aap_pkg::S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    div_num <= div_num << 1;
    div_rem <= div_rem_next;
    div_quo <= div_quo_next;
    div_cnt <= div_cnt - CNT_W'(1);
    case (state)
      aap_pkg::S_IDLE: begin
        row_q   <= row;
        col_q   <= col;
        bnd_idx <= 2'd0;
        if (accept && (func == aap_pkg::FUNC_COMPUTE) && !grid_ok) begin
          average     <= '0;
          range_error <= 1'b1;
        end
      end
      aap_pkg::S_BMUL: begin
        div_num <= {b_num, {(NUM_W-BND_W){1'b0}}};
        div_rem <= '0;
        div_quo <= '0;
        div_den <= REM_W'(b_out);
        div_cnt <= CNT_W'(BND_W);
      end
      aap_pkg::S_BDIV: begin
        if (div_cnt == CNT_W'(1)) begin
          bnd[bnd_idx] <= div_quo_next[DIM_W-1:0];
          bnd_idx      <= bnd_idx + 2'd1;
        end
      end
      aap_pkg::S_BASE: begin
        row_base <= ADDR_W'(32'(bnd[0]) * MAX_WIDTH);
        wr       <= bnd[0];
        wc       <= bnd[2];
        sum      <= '0;
      end
      aap_pkg::S_CNT: begin
        // sample count is the divisor of the mean
        div_den <= REM_W'(bnd[1] - bnd[0]) * REM_W'(bnd[3] - bnd[2]);
      end
      aap_pkg::S_WALK: begin
        if (rd_pend) sum <= sum_add;
        if (wc == bnd[3] - DIM_W'(1)) begin
          wc       <= bnd[2];
          wr       <= wr + DIM_W'(1);
          row_base <= row_base + ADDR_W'(MAX_WIDTH);
        end else begin
          wc <= wc + DIM_W'(1);
        end
      end
      aap_pkg::S_LAST: begin
        if (rd_pend) sum <= sum_add;
      end
      aap_pkg::S_MLOAD: begin
        div_num <= sum_abs[NUM_W-1:0];
        div_rem <= '0;
        div_quo <= '0;
        div_cnt <= CNT_W'(NUM_W);
        neg     <= sum[SUM_W-1];
      end
      aap_pkg::S_MDIV: begin
        if (div_cnt == CNT_W'(1)) begin
          average     <= neg ? SAMPLE_W'(-quo16) : quo16;
          range_error <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- checks
`include "adaptive_average_pool_2d_assert.svh"

  // a flagged result never carries a mean
  `AAP_ASSERT_IMPLY(a_flag_zero, clk, rst, result_valid && range_error, average == '0)
  // an in-grid compute always enters the sequencer
  `AAP_ASSERT_NEXT(a_compute_busy, clk, rst, accept && (func == aap_pkg::FUNC_COMPUTE) && grid_ok, busy)
  // the walk stays inside its window
  `AAP_ASSERT_IMPLY(a_walk_window, clk, rst, state == aap_pkg::S_WALK, (wr < bnd[1]) && (wc < bnd[3]))
  // the divider never runs out of steps while a division is pending
  `AAP_ASSERT_IMPLY(a_div_steps, clk, rst, (state == aap_pkg::S_BDIV) || (state == aap_pkg::S_MDIV), div_cnt != '0)

endmodule

`default_nettype wire

// ===== hdl/aap_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module aap_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 4096
) (
  input  wire logic                                     clk,
  input  wire logic                                     wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [DATA_W-1:0]                        wr_data,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [DATA_W-1:0]                        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire
